// ===== rtl/core/sprite_frame_sequencer_unit_defines.svh =====
// assertion helpers for the sprite frame sequencer
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

	localparam int unsigned OpW    = 3;
	localparam int unsigned TimeW  = 16;
	localparam int unsigned AccumW = 20;
	localparam int unsigned FrameW = 8;
	localparam int unsigned TileW  = FrameW + 1;
	localparam int unsigned TexUW  = 8;
	localparam int unsigned TexVW  = 9;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// input operations
	typedef enum logic [OpW-1:0] {
		OP_TICK       = 3'd0,
		OP_START_ONCE = 3'd1,
		OP_START_LOOP = 3'd2,
		OP_START_PING = 3'd3,
		OP_STOP       = 3'd4
	} op_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_FRAME_DELAY  = 3'd0,
		REG_TOTAL_FRAMES = 3'd1,
		REG_BASE_FRAME   = 3'd2,
		REG_TILE_WIDTH   = 3'd3,
		REG_TILE_HEIGHT  = 3'd4
	} reg_idx_t;

	// playback mode
	typedef enum logic [3:0] {
		MODE_STATIC = 4'b0001,
		MODE_ONCE   = 4'b0010,
		MODE_LOOP   = 4'b0100,
		MODE_PING   = 4'b1000
	} mode_t;

	localparam logic [AccumW-1:0] AccumMax = '1;
	localparam logic [7:0] TileSizeReset = 8'd16;

endpackage

`default_nettype wire

// ===== rtl/core/sfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface sfs_in_if;
	logic                           valid;
	logic                           ready;
	logic [sfs_pkg::OpW-1:0]        op;
	logic [sfs_pkg::TimeW-1:0]      time_delta;

	modport source (output valid, op, time_delta, input ready);
	modport sink (input valid, op, time_delta, output ready);
endinterface

// frame result channel
interface sfs_out_if;
	logic                           valid;
	logic                           ready;
	logic [sfs_pkg::TexUW-1:0]      tex_u;
	logic [sfs_pkg::TexVW-1:0]      tex_v;
	logic [sfs_pkg::FrameW-1:0]     frame_index;
	logic                           animating;

	modport source (output valid, tex_u, tex_v, frame_index, animating, input ready);
	modport sink (input valid, tex_u, tex_v, frame_index, animating, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sprite_frame_sequencer_unit.sv =====
// sprite animation frame sequencer
//
// channels: cmd_in (sink) takes one transaction per command: op is tick,
// start once, start loop, start ping-pong or stop; time_delta is the
// elapsed time of a tick in unsigned Q4.12 seconds. frame_out (source)
// carries one transaction per frame step with the texture u/v of the new
// frame, the frame number and whether the animation is still running.
// commands that do not step the frame give no transaction on frame_out.
// config port: cfg_wen/cfg_idx/cfg_data write one register per cycle; the
// user must write only while the block is idle; the block does not enforce it.
// path: a transaction taken into the input register passes the state/step
// stage and the multiply into the output register, which drives frame_out.
// throughput: one command per cycle, sustained while frame_out takes every
// result; the state update is a single 20-bit add, a compare and a frame
// step, so back-to-back ticks each see the state left by the one before.
// reset: arst_n clears mode to static, frame, accumulator and direction;
// tile sizes come up as 16, the other registers as 0.
// stall: when frame_out is not taken, full stages hold, empty ones fill,
// and cmd_in.ready drops once the pipeline is full; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_frame_sequencer_unit_defines.svh"

module sprite_frame_sequencer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [sfs_pkg::CfgIdxW-1:0]      cfg_idx,
	input  wire logic [sfs_pkg::CfgDataW-1:0]     cfg_data,
	sfs_in_if.sink                                cmd_in,
	sfs_out_if.source                             frame_out
);

	// configuration registers
	logic [sfs_pkg::TimeW-1:0]  frame_delay_q;
	logic [sfs_pkg::FrameW-1:0] total_frames_q;
	logic [sfs_pkg::FrameW-1:0] base_frame_q;
	logic [7:0]                 tile_width_q;
	logic [7:0]                 tile_height_q;

	// sequencer state
	sfs_pkg::mode_t             mode_q;
	logic [sfs_pkg::FrameW-1:0] frame_q;
	logic [sfs_pkg::AccumW-1:0] delay_accum_q;
	logic                       going_back_q;

	// stage 1: input register
	logic                       vld_s1;
	logic [sfs_pkg::OpW-1:0]    op_s1;
	logic [sfs_pkg::TimeW-1:0]  dt_s1;

	// stage 2: stepped frame and tile index
	logic                       vld_s2;
	logic [sfs_pkg::TileW-1:0]  tile_s2;
	logic [sfs_pkg::FrameW-1:0] frame_s2;
	logic                       anim_s2;

	// output register
	logic                       out_vld_q;
	logic [sfs_pkg::TexUW-1:0]  tex_u_q;
	logic [sfs_pkg::TexVW-1:0]  tex_v_q;
	logic [sfs_pkg::FrameW-1:0] frame_out_q;
	logic                       anim_out_q;

	// flow control
	logic out_adv;
	logic s2_free;
	logic s1_take;

	assign out_adv = !out_vld_q || frame_out.ready;
	assign s2_free = !vld_s2 || out_adv;
	assign s1_take = vld_s1 && s2_free;
	assign cmd_in.ready = !vld_s1 || s2_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_delay_q  <= '0;
			total_frames_q <= '0;
			base_frame_q   <= '0;
			tile_width_q   <= sfs_pkg::TileSizeReset;
			tile_height_q  <= sfs_pkg::TileSizeReset;
		end else if (cfg_wen) begin
			case (cfg_idx)
				sfs_pkg::REG_FRAME_DELAY:  frame_delay_q  <= cfg_data;
				sfs_pkg::REG_TOTAL_FRAMES: total_frames_q <= cfg_data[sfs_pkg::FrameW-1:0];
				sfs_pkg::REG_BASE_FRAME:   base_frame_q   <= cfg_data[sfs_pkg::FrameW-1:0];
				sfs_pkg::REG_TILE_WIDTH:   tile_width_q   <= cfg_data[7:0];
				sfs_pkg::REG_TILE_HEIGHT:  tile_height_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_in.ready) begin
			vld_s1 <= cmd_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.ready) begin
			op_s1 <= cmd_in.op;
			dt_s1 <= cmd_in.time_delta;
		end
	end

	// next-state logic for the command in stage 1
	logic [sfs_pkg::AccumW:0]   accum_sum;
	logic [sfs_pkg::AccumW-1:0] accum_sat;
	logic                       step;
	sfs_pkg::mode_t             mode_d;
	logic [sfs_pkg::FrameW-1:0] frame_d;
	logic [sfs_pkg::AccumW-1:0] accum_d;
	logic                       back_d;
	logic [sfs_pkg::FrameW-1:0] pp_frame;
	logic [sfs_pkg::FrameW-1:0] last_m1;

	always_comb begin
		accum_sum = {1'b0, delay_accum_q} + {{(sfs_pkg::AccumW + 1 - sfs_pkg::TimeW){1'b0}}, dt_s1};
		accum_sat = accum_sum[sfs_pkg::AccumW] ? sfs_pkg::AccumMax
			: accum_sum[sfs_pkg::AccumW-1:0];
		pp_frame  = going_back_q ? (frame_q - 8'd1) : (frame_q + 8'd1);
		last_m1   = total_frames_q - 8'd1;

		mode_d  = mode_q;
		frame_d = frame_q;
		accum_d = delay_accum_q;
		back_d  = going_back_q;
		step    = 1'b0;

		case (op_s1)
			sfs_pkg::OP_START_ONCE: mode_d = sfs_pkg::MODE_ONCE;
			sfs_pkg::OP_START_LOOP: mode_d = sfs_pkg::MODE_LOOP;
			sfs_pkg::OP_START_PING: mode_d = sfs_pkg::MODE_PING;
			sfs_pkg::OP_STOP:       mode_d = sfs_pkg::MODE_STATIC;
			sfs_pkg::OP_TICK: begin
				if (mode_q != sfs_pkg::MODE_STATIC) begin
					if (accum_sat <= {{(sfs_pkg::AccumW - sfs_pkg::TimeW){1'b0}}, frame_delay_q}) begin
						accum_d = accum_sat;
					end else begin
						step    = 1'b1;
						accum_d = '0;
						if (mode_q == sfs_pkg::MODE_PING) begin
							frame_d = pp_frame;
							if (pp_frame == '0 || pp_frame == last_m1) begin
								back_d = !going_back_q;
							end
						end else if (frame_q < total_frames_q) begin
							frame_d = frame_q + 8'd1;
						end else begin
							frame_d = '0;
							if (mode_q == sfs_pkg::MODE_ONCE) begin
								mode_d = sfs_pkg::MODE_STATIC;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= sfs_pkg::MODE_STATIC;
			frame_q       <= '0;
			delay_accum_q <= '0;
			going_back_q  <= 1'b0;
		end else if (s1_take) begin
			mode_q        <= mode_d;
			frame_q       <= frame_d;
			delay_accum_q <= accum_d;
			going_back_q  <= back_d;
		end
	end

	// stage 2: tile index of the new frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= s1_take && step;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			tile_s2  <= {1'b0, frame_d} + {1'b0, base_frame_q};
			frame_s2 <= frame_d;
			anim_s2  <= (mode_d != sfs_pkg::MODE_STATIC);
		end
	end

	// texture coordinates, one small multiply each
	logic [sfs_pkg::TileW+7:0] u_prod;
	logic [sfs_pkg::TileW+7:0] v_prod;

	assign u_prod = tile_s2 * {{(sfs_pkg::TileW){1'b0}}, tile_width_q};
	assign v_prod = tile_s2 * {{(sfs_pkg::TileW){1'b0}}, tile_height_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_adv) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			tex_u_q     <= u_prod[sfs_pkg::TexUW-1:0];
			tex_v_q     <= v_prod[8 +: sfs_pkg::TexVW];
			frame_out_q <= frame_s2;
			anim_out_q  <= anim_s2;
		end
	end

	assign frame_out.valid       = out_vld_q;
	assign frame_out.tex_u       = tex_u_q;
	assign frame_out.tex_v       = tex_v_q;
	assign frame_out.frame_index = frame_out_q;
	assign frame_out.animating   = anim_out_q;

	// checks
	`SFS_ASSERT_NEXT(a_static_keeps_accum, s1_take && mode_q == sfs_pkg::MODE_STATIC, $stable(delay_accum_q), "accumulator moved in static mode")
	`SFS_ASSERT_NEXT(a_step_clears_accum, s1_take && step, delay_accum_q == '0, "accumulator not cleared on frame step")
	`SFS_ASSERT_NEXT(a_step_frame_match, s1_take && step, vld_s2 && frame_s2 == frame_q, "stage 2 frame differs from state")
	`SFS_ASSERT_NEXT(a_s2_holds_on_stall, vld_s2 && !out_adv, vld_s2 && $stable(tile_s2), "stage 2 lost under stall")
	`SFS_ASSERT_NOW(a_no_take_when_full, vld_s1 && !s2_free, !cmd_in.ready, "input taken while stage 1 blocked")

endmodule

`default_nettype wire

// ===== sim/tb_sprite_frame_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer_unit;

	localparam int unsigned OpW      = sfs_pkg::OpW;
	localparam int unsigned TimeW    = sfs_pkg::TimeW;
	localparam int unsigned AccumW   = sfs_pkg::AccumW;
	localparam int unsigned FrameW   = sfs_pkg::FrameW;
	localparam int unsigned TileW    = sfs_pkg::TileW;
	localparam int unsigned TexUW    = sfs_pkg::TexUW;
	localparam int unsigned TexVW    = sfs_pkg::TexVW;
	localparam int unsigned CfgIdxW  = sfs_pkg::CfgIdxW;
	localparam int unsigned CfgDataW = sfs_pkg::CfgDataW;

	localparam int unsigned CycleLimit   = 200000;
	localparam int unsigned DrainCycles  = 8;
	localparam int unsigned IdlePercent  = 8;
	localparam int unsigned LongHold     = 200;
	localparam int unsigned PhaseItems   = 85;
	localparam int unsigned RandomPhases = 8;
	localparam int unsigned NumRegs      = 5;
	localparam logic [OpW-1:0] OpFirstUnused = OpW'(sfs_pkg::OP_STOP + 1);
	localparam logic [OpW-1:0] OpLastCode    = '1;

	// one frame transaction as it leaves the block
	typedef struct packed {
		logic [TexUW-1:0]  tex_u;
		logic [TexVW-1:0]  tex_v;
		logic [FrameW-1:0] frame_index;
		logic              animating;
	} frame_res_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_data;

	sfs_in_if  cmd_ch ();
	sfs_out_if frame_ch ();

	sprite_frame_sequencer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd_in   (cmd_ch),
		.frame_out(frame_ch)
	);

	// frame steps predicted but not yet seen on the output, oldest first
	frame_res_t pending_frames[$];

	// predictor copy of the registers
	logic [TimeW-1:0]  delay_reg;
	logic [FrameW-1:0] total_reg;
	logic [FrameW-1:0] base_reg;
	logic [FrameW-1:0] tile_w_reg;
	logic [FrameW-1:0] tile_h_reg;

	// predictor copy of the playback state
	sfs_pkg::mode_t    play_mode;
	logic [FrameW-1:0] cur_frame;
	logic [AccumW-1:0] time_accum;
	logic              going_back;
	logic              is_active;

	int errors;
	int sent_count;
	int checked_count;
	int settings_count;
	int hold_cycles;
	bit steady;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// applies one accepted command to the predicted state; a frame step
	// queues the transaction the block must produce for it
	function automatic void predict_frame_step(logic [OpW-1:0] op, logic [TimeW-1:0] dt);
		logic [AccumW:0] sum;
		logic [TileW-1:0] tile;
		logic [TileW+FrameW-1:0] prod_u;
		logic [TileW+FrameW-1:0] prod_v;
		frame_res_t res;
		if (op == sfs_pkg::OP_START_ONCE) begin
			play_mode = sfs_pkg::MODE_ONCE;
			is_active = 1'b1;
		end else if (op == sfs_pkg::OP_START_LOOP) begin
			play_mode = sfs_pkg::MODE_LOOP;
			is_active = 1'b1;
		end else if (op == sfs_pkg::OP_START_PING) begin
			play_mode = sfs_pkg::MODE_PING;
			is_active = 1'b1;
		end else if (op == sfs_pkg::OP_STOP) begin
			play_mode = sfs_pkg::MODE_STATIC;
			is_active = 1'b0;
		end else if (op == sfs_pkg::OP_TICK && play_mode != sfs_pkg::MODE_STATIC) begin
			// saturating accumulate, step only once strictly past the delay
			sum = {1'b0, time_accum} + {{(AccumW + 1 - TimeW){1'b0}}, dt};
			time_accum = (sum > {1'b0, sfs_pkg::AccumMax}) ? sfs_pkg::AccumMax
				: sum[AccumW-1:0];
			if (time_accum > {{(AccumW - TimeW){1'b0}}, delay_reg}) begin
				if (play_mode == sfs_pkg::MODE_PING) begin
					cur_frame = going_back ? cur_frame - 8'd1 : cur_frame + 8'd1;
					// turn around at frame 0 and at total-1, modulo 256
					if (cur_frame == '0 || cur_frame == total_reg - 8'd1)
						going_back = ~going_back;
				end else if (cur_frame < total_reg) begin
					cur_frame = cur_frame + 8'd1;
				end else begin
					cur_frame = '0;
					// play once ends here; the wrap still yields a transaction
					if (play_mode == sfs_pkg::MODE_ONCE) begin
						play_mode = sfs_pkg::MODE_STATIC;
						is_active = 1'b0;
					end
				end
				time_accum = '0;
				tile = {1'b0, cur_frame} + {1'b0, base_reg};
				prod_u = tile * {{TileW{1'b0}}, tile_w_reg};
				prod_v = tile * {{TileW{1'b0}}, tile_h_reg};
				res.tex_u = prod_u[TexUW-1:0];
				res.tex_v = prod_v[FrameW +: TexVW];
				res.frame_index = cur_frame;
				res.animating = is_active;
				pending_frames.push_back(res);
			end
		end
		// op codes above stop are ignored
	endfunction

	// offers one command starting at a falling edge, returns at the falling
	// edge after it was taken
	task automatic send_command(input logic [OpW-1:0] op, input logic [TimeW-1:0] dt);
		while (!steady && $urandom_range(0, 99) < IdlePercent) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.time_delta <= dt;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predict_frame_step(op, dt);
		sent_count++;
		@(negedge clk);
	endtask

	// stop offering and let every predicted frame come out
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		// commands without a result may still sit in the pipeline
		repeat (DrainCycles) @(negedge clk);
	endtask

	// writes all five registers on back-to-back cycles; block must be idle
	task automatic program_regs(input logic [TimeW-1:0] delay, input logic [FrameW-1:0] total,
			input logic [FrameW-1:0] base, input logic [FrameW-1:0] tile_w,
			input logic [FrameW-1:0] tile_h);
		sfs_pkg::reg_idx_t regs [NumRegs];
		logic [CfgDataW-1:0] vals [NumRegs];
		regs = '{sfs_pkg::REG_FRAME_DELAY, sfs_pkg::REG_TOTAL_FRAMES, sfs_pkg::REG_BASE_FRAME,
			sfs_pkg::REG_TILE_WIDTH, sfs_pkg::REG_TILE_HEIGHT};
		vals = '{CfgDataW'(delay), CfgDataW'(total), CfgDataW'(base), CfgDataW'(tile_w),
			CfgDataW'(tile_h)};
		for (int i = 0; i < NumRegs; i++) begin
			cfg_wen <= 1'b1;
			cfg_idx <= regs[i];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_wen <= 1'b0;
		delay_reg = delay;
		total_reg = total;
		base_reg = base;
		tile_w_reg = tile_w;
		tile_h_reg = tile_h;
		settings_count++;
	endtask

	// register reset values: static ticks, unused op codes, single-frame loop
	task automatic test_reset_state();
		send_command(sfs_pkg::OP_TICK, '1);
		for (logic [OpW:0] c = OpFirstUnused; c <= OpLastCode; c++)
			send_command(c[OpW-1:0], TimeW'($urandom));
		send_command(sfs_pkg::OP_START_LOOP, '0);
		send_command(sfs_pkg::OP_TICK, 16'd1);
		send_command(sfs_pkg::OP_STOP, '1);
		send_command(sfs_pkg::OP_TICK, '1);
		wait_drained();
	endtask

	// play once to its end, ping-pong with total 0, zero tile size,
	// mode switch keeping the frame, accumulator exactly at the delay
	task automatic test_directed_modes();
		program_regs('0, 8'd2, '1, '1, '1);
		send_command(sfs_pkg::OP_START_ONCE, '0);
		send_command(sfs_pkg::OP_TICK, '0);
		send_command(sfs_pkg::OP_TICK, '1);
		send_command(sfs_pkg::OP_TICK, 16'd1);
		send_command(sfs_pkg::OP_TICK, 16'd1);
		send_command(sfs_pkg::OP_TICK, 16'd1);
		wait_drained();

		program_regs(16'h1000, '0, 8'd200, '0, '0);
		send_command(sfs_pkg::OP_START_PING, '0);
		send_command(sfs_pkg::OP_TICK, 16'h1000);
		send_command(sfs_pkg::OP_TICK, 16'd1);
		send_command(sfs_pkg::OP_TICK, 16'h1001);
		send_command(sfs_pkg::OP_START_LOOP, '0);
		send_command(sfs_pkg::OP_TICK, '1);
		wait_drained();
	endtask

	// mostly start/tick sequences with random content, some stop and noise
	task automatic run_random_phase(input int n_items);
		logic [OpW-1:0] op;
		logic [TimeW-1:0] dt;
		int pick;
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				op = sfs_pkg::OP_TICK;
			else if (pick < 92)
				op = OpW'($urandom_range(sfs_pkg::OP_START_ONCE, sfs_pkg::OP_START_PING));
			else if (pick < 98)
				op = sfs_pkg::OP_STOP;
			else
				op = OpW'($urandom_range(OpFirstUnused, OpLastCode));
			// time deltas mostly a fraction of the delay so frames step every few ticks
			case ($urandom_range(0, 9))
				0: dt = '0;
				1: dt = '1;
				2, 3: dt = TimeW'($urandom);
				default: dt = TimeW'($urandom_range(0, (delay_reg >> 2) + 1));
			endcase
			send_command(op, dt);
		end
	endtask

	// register sweeps: both extremes first, then random settings
	task automatic test_random_traffic();
		for (int p = 0; p < RandomPhases; p++) begin
			case (p)
				0: program_regs('0, '0, '0, 8'd1, 8'd1);
				1: program_regs('1, '1, '1, '1, '1);
				default: program_regs(
					($urandom_range(0, 1) != 0) ? TimeW'($urandom_range(0, 16'h3000))
						: TimeW'($urandom),
					($urandom_range(0, 1) != 0) ? FrameW'($urandom_range(0, 6))
						: FrameW'($urandom),
					FrameW'($urandom),
					FrameW'($urandom_range(1, 255)),
					FrameW'($urandom_range(1, 255)));
			endcase
			// one phase runs with no idling on either side
			steady = (p == 5);
			send_command(OpW'($urandom_range(sfs_pkg::OP_START_ONCE, sfs_pkg::OP_START_PING)),
				'0);
			run_random_phase(PhaseItems);
			wait_drained();
		end
		steady = 1'b0;
	endtask

	// receiver holds off long enough for the block to fill and stall input
	task automatic test_output_stall();
		program_regs('0, 8'd4, FrameW'($urandom), FrameW'($urandom_range(1, 255)),
			FrameW'($urandom_range(1, 255)));
		send_command(sfs_pkg::OP_START_PING, '0);
		hold_cycles = LongHold;
		for (int k = 0; k < 40; k++)
			send_command(sfs_pkg::OP_TICK, TimeW'($urandom_range(1, 16'hFFFF)));
		wait_drained();
	endtask

	// sender stops mid-animation until every frame is out, then resumes
	task automatic test_sender_pause();
		program_regs(16'h0400, 8'd9, FrameW'($urandom), FrameW'($urandom_range(1, 255)),
			FrameW'($urandom_range(1, 255)));
		send_command(sfs_pkg::OP_START_LOOP, '0);
		run_random_phase(30);
		cmd_ch.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		@(negedge clk);
		run_random_phase(30);
		wait_drained();
	endtask

	// result side: random stalls, or a counted hold-off when requested
	initial begin
		frame_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				frame_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (steady) begin
				frame_ch.ready <= 1'b1;
			end else begin
				frame_ch.ready <= ($urandom_range(0, 99) >= IdlePercent);
			end
		end
	end

	// every frame transaction against the oldest prediction
	always @(posedge clk) begin : check_frames
		frame_res_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (pending_frames.size() == 0) begin
				$error("frame transaction with no frame step pending: frame_index %0d",
					frame_ch.frame_index);
				errors++;
			end else begin
				want = pending_frames.pop_front();
				checked_count++;
				if (frame_ch.tex_u !== want.tex_u) begin
					$error("tex_u expected %0d actual %0d", want.tex_u, frame_ch.tex_u);
					errors++;
				end
				if (frame_ch.tex_v !== want.tex_v) begin
					$error("tex_v expected %0d actual %0d", want.tex_v, frame_ch.tex_v);
					errors++;
				end
				if (frame_ch.frame_index !== want.frame_index) begin
					$error("frame_index expected %0d actual %0d", want.frame_index,
						frame_ch.frame_index);
					errors++;
				end
				if (frame_ch.animating !== want.animating) begin
					$error("animating expected %0d actual %0d", want.animating,
						frame_ch.animating);
					errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("timeout after %0d cycles, %0d frames still pending", CycleLimit,
			pending_frames.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		errors = 0;
		sent_count = 0;
		checked_count = 0;
		settings_count = 0;
		hold_cycles = 0;
		steady = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = sfs_pkg::OP_TICK;
		cmd_ch.time_delta = '0;
		cfg_wen = 1'b0;
		cfg_idx = sfs_pkg::REG_FRAME_DELAY;
		cfg_data = '0;
		arst_n = 1'b0;

		// predictor starts from the reset state of the block
		delay_reg = '0;
		total_reg = '0;
		base_reg = '0;
		tile_w_reg = sfs_pkg::TileSizeReset;
		tile_h_reg = sfs_pkg::TileSizeReset;
		play_mode = sfs_pkg::MODE_STATIC;
		cur_frame = '0;
		time_accum = '0;
		going_back = 1'b0;
		is_active = 1'b0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed_modes();
		test_random_traffic();
		test_output_stall();
		test_sender_pause();

		wait_drained();
		if (pending_frames.size() != 0) begin
			$error("%0d predicted frames never arrived", pending_frames.size());
			errors++;
		end
		$display("run covered %0d commands and %0d checked frames over %0d register settings",
			sent_count, checked_count, settings_count);
		$display("modes once, loop and ping-pong with stop, unused codes and output stalls");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sfs_pkg.sv
rtl/core/sfs_if.sv
rtl/core/sprite_frame_sequencer_unit.sv
sim/tb_sprite_frame_sequencer_unit.sv
